>>> sv/vfr_pkg.sv
package vfr_pkg;

   localparam int CODE_W   = 24;
   localparam int SCALE_W  = 32;
   localparam int DIAM_W   = 20;
   localparam int DENS_W   = 32;
   localparam int DIFF_W   = 40;
   localparam int FLOW_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int PROD_W = CODE_W + SCALE_W;
   localparam int Y_W    = 112;
   localparam int K_W    = 197;
   localparam int N_W    = 188;
   localparam int Q_W    = 64;
   localparam int ROOT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INLET     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THROAT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 3'd4;

   localparam logic [DIAM_W-1:0]  RST_INLET   = 20'd20000;
   localparam logic [DIAM_W-1:0]  RST_THROAT  = 20'd10000;
   localparam logic [DENS_W-1:0]  RST_DENSITY = 32'd65536000;
   localparam logic [SCALE_W-1:0] RST_SCALE   = 32'd16777216;

   localparam logic [DIFF_W-1:0] ATM_Q8     = 40'd25939200;
   localparam logic [36:0]       FLOW_GAIN  = 37'd85377152668;
   localparam logic [DIFF_W-1:0] DIFF_MAX   = {1'b0, {(DIFF_W-1){1'b1}}};
   localparam logic [DIFF_W-1:0] DIFF_MIN   = {1'b1, {(DIFF_W-1){1'b0}}};

   typedef struct packed {
      logic               mode;
      logic [SCALE_W-1:0] scale;
      logic [Y_W-1:0]     y;
      logic [K_W-1:0]     k;
      logic               zero_throat;
      logic               sat;
      logic               busy;
   } coef_type;

   typedef struct packed {
      logic [DIFF_W-1:0] diff;
      logic              no_flow;
      logic              sat;
   } side_type;

endpackage

>>> sv/vfr_req_if.sv
interface vfr_req_if;
   logic                       valid;
   logic                       ready;
   logic [vfr_pkg::CODE_W-1:0] code_a;
   logic [vfr_pkg::CODE_W-1:0] code_b;

   modport source (output valid, output code_a, output code_b, input ready);
   modport sink (input valid, input code_a, input code_b, output ready);
endinterface

>>> sv/vfr_rsp_if.sv
interface vfr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [vfr_pkg::FLOW_W-1:0]        flow_rate_mm3s;
   logic signed [vfr_pkg::DIFF_W-1:0] pressure_diff;
   logic                              no_flow;

   modport source (output valid, output flow_rate_mm3s, output pressure_diff,
                   output no_flow, input ready);
   modport sink (input valid, input flow_rate_mm3s, input pressure_diff,
                 input no_flow, output ready);
endinterface

>>> sv/vfr_coef.sv
module vfr_coef (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [vfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vfr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output vfr_pkg::coef_type                  coef
);

   localparam int A_W       = 160;
   localparam int B_W       = 80;
   localparam int ACC_W     = A_W + B_W;
   localparam int CNT_W     = $clog2(B_W);

   typedef enum logic [2:0] {OP_A1, OP_A2, OP_P1, OP_P2, OP_Y, OP_T, OP_K} op_type;

   op_type                        op_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          busy_ff;
   logic [ACC_W-1:0]              acc_ff;
   logic [ACC_W-1:0]              acc_in;
   logic                          mode_ff;
   logic [vfr_pkg::DIAM_W-1:0]    d1_ff;
   logic [vfr_pkg::DIAM_W-1:0]    d2_ff;
   logic [vfr_pkg::DENS_W-1:0]    rho_ff;
   logic [vfr_pkg::SCALE_W-1:0]   scale_ff;
   logic [39:0]                   a1_ff;
   logic [39:0]                   a2_ff;
   logic [79:0]                   p1_ff;
   logic [79:0]                   p2_ff;
   logic [vfr_pkg::Y_W-1:0]       y_ff;
   logic [159:0]                  t_ff;
   logic [vfr_pkg::K_W-1:0]       k_ff;
   logic [A_W-1:0]                opa;
   logic [B_W-1:0]                opb;
   logic                          b_bit;
   logic                          last_bit;

   // operand select per step of the coefficient sequence
   always_comb begin
      opa = '0;
      opb = '0;
      unique case (op_ff)
         OP_A1: begin
            opa = A_W'(d1_ff);
            opb = B_W'(d1_ff);
         end
         OP_A2: begin
            opa = A_W'(d2_ff);
            opb = B_W'(d2_ff);
         end
         OP_P1: begin
            opa = A_W'(a1_ff);
            opb = B_W'(a1_ff);
         end
         OP_P2: begin
            opa = A_W'(a2_ff);
            opb = B_W'(a2_ff);
         end
         OP_Y: begin
            opa = A_W'(p1_ff - p2_ff);
            opb = B_W'(rho_ff);
         end
         OP_T: begin
            opa = A_W'(p1_ff);
            opb = B_W'(p2_ff);
         end
         OP_K: begin
            opa = t_ff;
            opb = B_W'(vfr_pkg::FLOW_GAIN);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // shift-add multiply, msb of opb first
   assign b_bit    = opb[CNT_W'(B_W - 1) - cnt_ff];
   assign last_bit = (cnt_ff == CNT_W'(B_W - 1));
   assign acc_in   = ((cnt_ff == '0) ? '0 : {acc_ff[ACC_W-2:0], 1'b0})
                     + (b_bit ? ACC_W'(opa) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         d1_ff    <= vfr_pkg::RST_INLET;
         d2_ff    <= vfr_pkg::RST_THROAT;
         rho_ff   <= vfr_pkg::RST_DENSITY;
         scale_ff <= vfr_pkg::RST_SCALE;
         busy_ff  <= 1'b1;
         op_ff    <= OP_A1;
         cnt_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vfr_pkg::CSR_FLOW_MODE: mode_ff  <= csr_wdata[0];
            vfr_pkg::CSR_INLET:     d1_ff    <= csr_wdata[vfr_pkg::DIAM_W-1:0];
            vfr_pkg::CSR_THROAT:    d2_ff    <= csr_wdata[vfr_pkg::DIAM_W-1:0];
            vfr_pkg::CSR_DENSITY:   rho_ff   <= csr_wdata[vfr_pkg::DENS_W-1:0];
            vfr_pkg::CSR_SCALE:     scale_ff <= csr_wdata[vfr_pkg::SCALE_W-1:0];
            default: ;
         endcase
         busy_ff <= 1'b1;
         op_ff   <= OP_A1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         if (last_bit) begin
            cnt_ff <= '0;
            unique case (op_ff)
               OP_A1:   a1_ff <= acc_in[39:0];
               OP_A2:   a2_ff <= acc_in[39:0];
               OP_P1:   p1_ff <= acc_in[79:0];
               OP_P2:   p2_ff <= acc_in[79:0];
               OP_Y:    y_ff  <= acc_in[vfr_pkg::Y_W-1:0];
               OP_T:    t_ff  <= acc_in[159:0];
               OP_K:    k_ff  <= acc_in[vfr_pkg::K_W-1:0];
               default: ;
            endcase
            if (op_ff == OP_K) begin
               busy_ff <= 1'b0;
            end else begin
               op_ff <= op_type'(op_ff + 3'd1);
            end
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign coef.mode        = mode_ff;
   assign coef.scale       = scale_ff;
   assign coef.y           = y_ff;
   assign coef.k           = k_ff;
   assign coef.zero_throat = (d2_ff == '0);
   assign coef.sat         = (d2_ff >= d1_ff) || (rho_ff == '0);
   assign coef.busy        = busy_ff;

`ifndef NO_ASSERTIONS
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy_ff && (cnt_ff == '0) && (op_ff == OP_A1))
      else $error("csr write did not restart coefficient sequence");
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (cnt_ff == '0))
      else $error("bit count moving while sequence idle");
   a_idle_last_op: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (op_ff == OP_K))
      else $error("sequence idle before last step");
`endif

endmodule

>>> sv/vfr_front.sv
module vfr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_vld,
   input  logic [vfr_pkg::CODE_W-1:0]    code_a,
   input  logic [vfr_pkg::CODE_W-1:0]    code_b,
   input  vfr_pkg::coef_type             coef,
   output logic                          out_vld,
   output vfr_pkg::side_type             out_side,
   output logic [vfr_pkg::Y_W-1:0]       out_rem,
   output logic [vfr_pkg::Q_W-1:0]       out_low
);

   localparam int KX_W  = 224;
   localparam int LIMBS = KX_W / 32;
   localparam int PP_W  = 52;
   localparam int PL_W  = 217;
   localparam int NUM_W = 236;
   localparam int H_W   = vfr_pkg::N_W - vfr_pkg::Q_W;

   // stage 1: scale codes
   logic                          s1_vld_ff;
   logic [vfr_pkg::PROD_W-1:0]    s1_pa_ff;
   logic [vfr_pkg::PROD_W-1:0]    s1_pb_ff;

   // stage 2: saturated difference
   logic                          s2_vld_ff;
   logic [vfr_pkg::DIFF_W-1:0]    s2_diff_ff;
   logic                          s2_nf_ff;
   logic [vfr_pkg::DIFF_W-1:0]    diff_in;
   logic [vfr_pkg::DIFF_W:0]      diff_wide;
   logic [vfr_pkg::DIFF_W-1:0]    pb;

   // stage 3: partial products
   logic                          s3_vld_ff;
   logic [vfr_pkg::DIFF_W-1:0]    s3_diff_ff;
   logic                          s3_nf_ff;
   logic [KX_W-1:0]               s3_ev_lo_ff;
   logic [KX_W-1:0]               s3_od_lo_ff;
   logic [KX_W-1:0]               s3_ev_hi_ff;
   logic [KX_W-1:0]               s3_od_hi_ff;
   logic [KX_W-1:0]               ev_lo;
   logic [KX_W-1:0]               od_lo;
   logic [KX_W-1:0]               ev_hi;
   logic [KX_W-1:0]               od_hi;
   logic [KX_W-1:0]               kx;
   logic [PP_W-1:0]               pp_lo [0:LIMBS-1];
   logic [PP_W-1:0]               pp_hi [0:LIMBS-1];

   // stage 4: half products
   logic                          s4_vld_ff;
   logic [vfr_pkg::DIFF_W-1:0]    s4_diff_ff;
   logic                          s4_nf_ff;
   logic [PL_W-1:0]               s4_lo_ff;
   logic [PL_W-1:0]               s4_hi_ff;

   // stage 5: full numerator
   logic                          s5_vld_ff;
   logic [vfr_pkg::DIFF_W-1:0]    s5_diff_ff;
   logic                          s5_nf_ff;
   logic [vfr_pkg::N_W-1:0]       s5_n_ff;
   logic [NUM_W-1:0]              num_in;

   // stage 6: range check
   logic                          s6_vld_ff;
   vfr_pkg::side_type             s6_side_ff;
   logic [vfr_pkg::Y_W-1:0]       s6_rem_ff;
   logic [vfr_pkg::Q_W-1:0]       s6_low_ff;
   logic [H_W-1:0]                h;

   assign pb        = coef.mode ? s1_pb_ff[vfr_pkg::PROD_W-1:16] : vfr_pkg::ATM_Q8;
   assign diff_wide = {1'b0, s1_pa_ff[vfr_pkg::PROD_W-1:16]} - {1'b0, pb};

   always_comb begin
      if (diff_wide[vfr_pkg::DIFF_W] != diff_wide[vfr_pkg::DIFF_W-1]) begin
         diff_in = diff_wide[vfr_pkg::DIFF_W] ? vfr_pkg::DIFF_MIN : vfr_pkg::DIFF_MAX;
      end else begin
         diff_in = diff_wide[vfr_pkg::DIFF_W-1:0];
      end
   end

   assign kx = KX_W'(coef.k);

   for (genvar g = 0; g < LIMBS; g++) begin : g_limb
      assign pp_lo[g] = PP_W'(kx[32*g +: 32]) * PP_W'(s2_diff_ff[19:0]);
      assign pp_hi[g] = PP_W'(kx[32*g +: 32]) * PP_W'(s2_diff_ff[38:20]);
   end

   // even and odd limb products do not overlap, so each set packs side by side
   always_comb begin
      ev_lo = '0;
      od_lo = '0;
      ev_hi = '0;
      od_hi = '0;
      for (int e = 0; e < LIMBS / 2; e++) begin
         ev_lo[64*e +: 64] = 64'(pp_lo[2*e]);
         ev_hi[64*e +: 64] = 64'(pp_hi[2*e]);
      end
      // top limb of k holds only a few bits
      ev_lo[KX_W-32 +: 32] = pp_lo[LIMBS-1][31:0];
      ev_hi[KX_W-32 +: 32] = pp_hi[LIMBS-1][31:0];
      for (int o = 0; o < LIMBS / 2; o++) begin
         od_lo[64*o + 32 +: 64] = 64'(pp_lo[2*o + 1]);
         od_hi[64*o + 32 +: 64] = 64'(pp_hi[2*o + 1]);
      end
   end

   assign num_in = NUM_W'(s4_lo_ff) + (NUM_W'(s4_hi_ff) << 20);
   assign h      = s5_n_ff[vfr_pkg::N_W-1:vfr_pkg::Q_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pa_ff    <= vfr_pkg::PROD_W'(code_a) * vfr_pkg::PROD_W'(coef.scale);
         s1_pb_ff    <= vfr_pkg::PROD_W'(code_b) * vfr_pkg::PROD_W'(coef.scale);
         s2_diff_ff  <= diff_in;
         s2_nf_ff    <= diff_in[vfr_pkg::DIFF_W-1] || (diff_in == '0);
         s3_diff_ff  <= s2_diff_ff;
         s3_nf_ff    <= s2_nf_ff;
         s3_ev_lo_ff <= ev_lo;
         s3_od_lo_ff <= od_lo;
         s3_ev_hi_ff <= ev_hi;
         s3_od_hi_ff <= od_hi;
         s4_diff_ff  <= s3_diff_ff;
         s4_nf_ff    <= s3_nf_ff;
         s4_lo_ff    <= PL_W'(s3_ev_lo_ff + s3_od_lo_ff);
         s4_hi_ff    <= PL_W'(s3_ev_hi_ff + s3_od_hi_ff);
         s5_diff_ff  <= s4_diff_ff;
         s5_nf_ff    <= s4_nf_ff;
         s5_n_ff     <= num_in[NUM_W-1:48];
         s6_side_ff.diff    <= s5_diff_ff;
         s6_side_ff.no_flow <= s5_nf_ff;
         s6_side_ff.sat     <= (h >= H_W'(coef.y));
         s6_rem_ff   <= h[vfr_pkg::Y_W-1:0];
         s6_low_ff   <= s5_n_ff[vfr_pkg::Q_W-1:0];
      end
   end

   assign out_vld  = s6_vld_ff;
   assign out_side = s6_side_ff;
   assign out_rem  = s6_rem_ff;
   assign out_low  = s6_low_ff;

endmodule

>>> sv/vfr_div.sv
module vfr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [vfr_pkg::Y_W-1:0]    y,
   input  logic                       in_vld,
   input  vfr_pkg::side_type          in_side,
   input  logic [vfr_pkg::Y_W-1:0]    in_rem,
   input  logic [vfr_pkg::Q_W-1:0]    in_low,
   output logic                       out_vld,
   output vfr_pkg::side_type          out_side,
   output logic [vfr_pkg::Q_W-1:0]    out_q
);

   localparam int STEPS = vfr_pkg::Q_W;

   logic                        vld_s  [0:STEPS];
   vfr_pkg::side_type           side_s [0:STEPS];
   logic [vfr_pkg::Y_W-1:0]     rem_s  [0:STEPS];
   logic [vfr_pkg::Q_W-1:0]     low_s  [0:STEPS];

   assign vld_s[0]  = in_vld;
   assign side_s[0] = in_side;
   assign rem_s[0]  = in_rem;
   assign low_s[0]  = in_low;

   // one quotient bit per stage, shifted in as the dividend bits shift out
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic [vfr_pkg::Y_W:0] t;
      logic                  ge;

      assign t  = {rem_s[g], low_s[g][vfr_pkg::Q_W-1]};
      assign ge = (t >= {1'b0, y});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_s[g+1] <= 1'b0;
         end else if (adv) begin
            vld_s[g+1] <= vld_s[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_s[g+1] <= side_s[g];
            rem_s[g+1]  <= ge ? vfr_pkg::Y_W'(t - {1'b0, y}) : t[vfr_pkg::Y_W-1:0];
            low_s[g+1]  <= {low_s[g][vfr_pkg::Q_W-2:0], ge};
         end
      end
   end

   assign out_vld  = vld_s[STEPS];
   assign out_side = side_s[STEPS];
   assign out_q    = low_s[STEPS];

endmodule

>>> sv/vfr_sqrt.sv
module vfr_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          zero_throat,
   input  logic                          cfg_sat,
   input  logic                          in_vld,
   input  vfr_pkg::side_type             in_side,
   input  logic [vfr_pkg::Q_W-1:0]       in_q,
   output logic                          out_vld,
   output logic [vfr_pkg::FLOW_W-1:0]    out_flow,
   output logic [vfr_pkg::DIFF_W-1:0]    out_diff,
   output logic                          out_no_flow
);

   localparam int STEPS = vfr_pkg::ROOT_W;
   localparam int REM_W = vfr_pkg::ROOT_W + 3;

   logic                          vld_s  [0:STEPS];
   vfr_pkg::side_type             side_s [0:STEPS];
   logic [REM_W-1:0]              rem_s  [0:STEPS];
   logic [vfr_pkg::ROOT_W-1:0]    root_s [0:STEPS];
   logic [vfr_pkg::Q_W-1:0]       qs_s   [0:STEPS];
   logic                          out_vld_ff;
   logic [vfr_pkg::FLOW_W-1:0]    out_flow_ff;
   logic [vfr_pkg::DIFF_W-1:0]    out_diff_ff;
   logic                          out_nf_ff;
   logic [vfr_pkg::FLOW_W-1:0]    flow_in;

   assign vld_s[0]  = in_vld;
   assign side_s[0] = in_side;
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign qs_s[0]   = in_q;

   // digit-by-digit root, two radicand bits per stage
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic [REM_W-1:0] r2;
      logic [REM_W-1:0] trial;
      logic             ge;

      assign r2    = {rem_s[g][REM_W-3:0], qs_s[g][vfr_pkg::Q_W-1 -: 2]};
      assign trial = REM_W'({root_s[g], 2'b01});
      assign ge    = (r2 >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_s[g+1] <= 1'b0;
         end else if (adv) begin
            vld_s[g+1] <= vld_s[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_s[g+1] <= side_s[g];
            rem_s[g+1]  <= ge ? (r2 - trial) : r2;
            root_s[g+1] <= {root_s[g][vfr_pkg::ROOT_W-2:0], ge};
            qs_s[g+1]   <= {qs_s[g][vfr_pkg::Q_W-3:0], 2'b00};
         end
      end
   end

   always_comb begin
      if (side_s[STEPS].no_flow || zero_throat) begin
         flow_in = '0;
      end else if (cfg_sat || side_s[STEPS].sat) begin
         flow_in = '1;
      end else begin
         flow_in = root_s[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_s[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_flow_ff <= flow_in;
         out_diff_ff <= side_s[STEPS].diff;
         out_nf_ff   <= side_s[STEPS].no_flow;
      end
   end

   assign out_vld     = out_vld_ff;
   assign out_flow    = out_flow_ff;
   assign out_diff    = out_diff_ff;
   assign out_no_flow = out_nf_ff;

endmodule

>>> sv/venturi_flow_rate.sv
// channel   dir  handshake      payload
// req_ch    in   valid/ready    code_a, code_b
// rsp_ch    out  valid/ready    flow_rate_mm3s, pressure_diff, no_flow
// csr       in   csr_we         csr_index, csr_wdata
//
// one transfer per cycle in, one out, when neither stalled nor busy; stages:
// (6 front stages, 64 divider stages, 32 root stages, output register)
// after reset and after each csr write a bit-serial coefficient
// sequence runs with req_ch.ready low
// a stalled rsp_ch holds the whole pipeline in place
module venturi_flow_rate (
   input  logic                           clock,
   input  logic                           reset,
   vfr_req_if.sink                        req_ch,
   vfr_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [vfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vfr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   vfr_pkg::coef_type             coef;
   logic                          adv;
   logic                          accept;
   logic                          fr_vld;
   vfr_pkg::side_type             fr_side;
   logic [vfr_pkg::Y_W-1:0]       fr_rem;
   logic [vfr_pkg::Q_W-1:0]       fr_low;
   logic                          dv_vld;
   vfr_pkg::side_type             dv_side;
   logic [vfr_pkg::Q_W-1:0]       dv_q;
   logic                          out_vld;
   logic [vfr_pkg::DIFF_W-1:0]    out_diff;

   assign adv          = !out_vld || rsp_ch.ready;
   assign req_ch.ready = adv && !coef.busy;
   assign accept       = req_ch.valid && req_ch.ready;

   vfr_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   vfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (accept),
      .code_a   (req_ch.code_a),
      .code_b   (req_ch.code_b),
      .coef     (coef),
      .out_vld  (fr_vld),
      .out_side (fr_side),
      .out_rem  (fr_rem),
      .out_low  (fr_low)
   );

   vfr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .y        (coef.y),
      .in_vld   (fr_vld),
      .in_side  (fr_side),
      .in_rem   (fr_rem),
      .in_low   (fr_low),
      .out_vld  (dv_vld),
      .out_side (dv_side),
      .out_q    (dv_q)
   );

   vfr_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .zero_throat (coef.zero_throat),
      .cfg_sat     (coef.sat),
      .in_vld      (dv_vld),
      .in_side     (dv_side),
      .in_q        (dv_q),
      .out_vld     (out_vld),
      .out_flow    (rsp_ch.flow_rate_mm3s),
      .out_diff    (out_diff),
      .out_no_flow (rsp_ch.no_flow)
   );

   assign rsp_ch.valid         = out_vld;
   assign rsp_ch.pressure_diff = signed'(out_diff);

`ifndef NO_ASSERTIONS
   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      coef.busy |-> !req_ch.ready)
      else $error("input transfer taken during coefficient sequence");
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input transfer taken while output stalled");
   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid
         && $stable(rsp_ch.flow_rate_mm3s) && $stable(rsp_ch.pressure_diff)
         && $stable(rsp_ch.no_flow)))
      else $error("result changed while output stalled");
`endif

endmodule

>>> sim/venturi_flow_rate_test.sv
module venturi_flow_rate_test;

   typedef struct {
      logic [vfr_pkg::FLOW_W-1:0] flow;
      logic [vfr_pkg::DIFF_W-1:0] diff;
      logic                       no_flow;
   } flow_result_type;

   typedef struct {
      logic [vfr_pkg::CODE_W-1:0] code_a;
      logic [vfr_pkg::CODE_W-1:0] code_b;
      bit                         typed;
      flow_result_type            want;
   } stim_row_type;

   localparam int PHASES   = 10;
   localparam int PER_PHASE = 160;

   logic clock;
   logic reset;
   logic csr_we;
   logic [vfr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [vfr_pkg::CSR_DATA_W-1:0] csr_wdata;

   vfr_req_if req_ch();
   vfr_rsp_if rsp_ch();

   venturi_flow_rate uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the register file
   logic                        mode_r;
   logic [vfr_pkg::DIAM_W-1:0]  inlet_r;
   logic [vfr_pkg::DIAM_W-1:0]  throat_r;
   logic [vfr_pkg::DENS_W-1:0]  density_r;
   logic [vfr_pkg::SCALE_W-1:0] scale_r;

   flow_result_type pending_flows[$];
   int  mismatches;
   bit  quiet;
   bit  stall_req;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("venturi_flow_rate regression: fail");
      $finish;
   end

   function automatic logic [31:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [31:0] bernoulli_flow(logic [vfr_pkg::DIFF_W-1:0] dp);
      logic [255:0] d1p;
      logic [255:0] d2p;
      logic [255:0] num;
      logic [255:0] den;
      logic [255:0] quo;
      if (throat_r == 0) return 32'd0;
      if (throat_r >= inlet_r || density_r == 0) return 32'hFFFF_FFFF;
      d1p = 256'(inlet_r) * inlet_r * inlet_r * inlet_r;
      d2p = 256'(throat_r) * throat_r * throat_r * throat_r;
      den = ((d1p - d2p) * density_r) << 48;
      num = 256'(vfr_pkg::FLOW_GAIN) * d1p * d2p * dp;
      quo = num / den;
      if (quo >= (256'd1 << 64)) return 32'hFFFF_FFFF;
      return root_floor(quo[63:0]);
   endfunction

   function automatic flow_result_type predict_flow(logic [vfr_pkg::CODE_W-1:0] a,
                                                    logic [vfr_pkg::CODE_W-1:0] b);
      flow_result_type r;
      longint pa;
      longint pb;
      longint dp;
      logic [63:0] prod;
      prod = (64'(a) * scale_r) >> 16;
      pa   = longint'(prod);
      pb   = longint'(vfr_pkg::ATM_Q8);
      if (mode_r) begin
         prod = (64'(b) * scale_r) >> 16;
         pb   = longint'(prod);
      end
      dp = pa - pb;
      if (dp > 64'sd549755813887) dp = 64'sd549755813887;
      if (dp < -64'sd549755813888) dp = -64'sd549755813888;
      r.diff = dp[vfr_pkg::DIFF_W-1:0];
      if (dp <= 0) begin
         r.flow    = 0;
         r.no_flow = 1'b1;
      end else begin
         r.flow    = bernoulli_flow(dp[vfr_pkg::DIFF_W-1:0]);
         r.no_flow = 1'b0;
      end
      return r;
   endfunction

   task automatic csr_write(logic [vfr_pkg::CSR_IDX_W-1:0] idx,
                            logic [vfr_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         vfr_pkg::CSR_FLOW_MODE: mode_r    = data[0];
         vfr_pkg::CSR_INLET:     inlet_r   = data[vfr_pkg::DIAM_W-1:0];
         vfr_pkg::CSR_THROAT:    throat_r  = data[vfr_pkg::DIAM_W-1:0];
         vfr_pkg::CSR_DENSITY:   density_r = data;
         vfr_pkg::CSR_SCALE:     scale_r   = data;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_flows.size() != 0) @(posedge clock);
   endtask

   task automatic offer(logic [vfr_pkg::CODE_W-1:0] a, logic [vfr_pkg::CODE_W-1:0] b,
                        bit typed, flow_result_type want);
      flow_result_type got;
      if (!quiet && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.code_a <= a;
      req_ch.code_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      got = predict_flow(a, b);
      if (typed) got = want;
      pending_flows.push_back(got);
   endtask

   function automatic logic [vfr_pkg::CODE_W-1:0] pick_code();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return vfr_pkg::CODE_W'(101315 + $urandom_range(20));
         default: return vfr_pkg::CODE_W'($urandom);
      endcase
   endfunction

   // receiving side
   initial begin
      flow_result_type exp_r;
      forever begin
         if (stall_req) begin
            stall_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_ch.ready <= quiet || ($urandom_range(99) >= 25);
            @(posedge clock);
            if (!reset && rsp_ch.valid && rsp_ch.ready) begin
               if (pending_flows.size() == 0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("unexpected transfer flow=%0d", rsp_ch.flow_rate_mm3s);
               end else begin
                  exp_r = pending_flows.pop_front();
                  if (rsp_ch.flow_rate_mm3s !== exp_r.flow
                      || rsp_ch.pressure_diff !== exp_r.diff
                      || rsp_ch.no_flow !== exp_r.no_flow) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display("mismatch exp flow=%0d diff=%h nf=%b got flow=%0d diff=%h nf=%b",
                                 exp_r.flow, exp_r.diff, exp_r.no_flow, rsp_ch.flow_rate_mm3s,
                                 rsp_ch.pressure_diff, rsp_ch.no_flow);
                  end
               end
            end
         end
      end
   end

   // sending side
   initial begin
      stim_row_type    rows[$];
      stim_row_type    row;
      flow_result_type none_r;
      logic [vfr_pkg::CODE_W-1:0] a;
      logic [vfr_pkg::CODE_W-1:0] b;
      int waited;
      mismatches = 0;
      quiet      = 1'b0;
      stall_req  = 1'b0;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.code_a <= '0;
      req_ch.code_b <= '0;
      mode_r    = 1'b0;
      inlet_r   = vfr_pkg::RST_INLET;
      throat_r  = vfr_pkg::RST_THROAT;
      density_r = vfr_pkg::RST_DENSITY;
      scale_r   = vfr_pkg::RST_SCALE;
      none_r    = '{flow: '0, diff: '0, no_flow: 1'b0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      rows.push_back('{24'd0, 24'd0, 1, '{32'd0, -40'sd25939200, 1'b1}});
      rows.push_back('{24'd101325, 24'hFFFFFF, 1, '{32'd0, 40'd0, 1'b1}});
      rows.push_back('{24'd101326, 24'hFFFFFF, 0, none_r});
      rows.push_back('{24'hFFFFFF, 24'd0, 0, none_r});
      rows.push_back('{24'h555555, 24'hAAAAAA, 0, none_r});
      rows.push_back('{24'hAAAAAA, 24'h555555, 0, none_r});
      rows.push_back('{24'd200000, 24'd123, 0, none_r});
      rows.push_back('{24'd101324, 24'd0, 1, '{32'd0, -40'sd256, 1'b1}});
      foreach (rows[i]) begin
         row = rows[i];
         offer(row.code_a, row.code_b, row.typed, row.want);
      end
      req_ch.valid <= 1'b0;

      for (int ph = 1; ph < PHASES; ph++) begin
         wait_drained();
         repeat (110) @(posedge clock);
         case (ph)
            1: begin
               csr_write(vfr_pkg::CSR_FLOW_MODE, 32'hFFFF_FFFF);
            end
            2: begin
               csr_write(vfr_pkg::CSR_FLOW_MODE, 32'hFFFF_FFFE);
               csr_write(vfr_pkg::CSR_INLET, 32'hFFF4_4240);
               csr_write(vfr_pkg::CSR_THROAT, 32'hFFF0_0001);
               csr_write(vfr_pkg::CSR_DENSITY, 32'd1);
               csr_write(vfr_pkg::CSR_SCALE, 32'hFFFF_FFFF);
            end
            3: begin
               csr_write(vfr_pkg::CSR_FLOW_MODE, 32'd1);
               csr_write(vfr_pkg::CSR_INLET, 32'd2);
               csr_write(vfr_pkg::CSR_THROAT, 32'd1);
               csr_write(vfr_pkg::CSR_DENSITY, 32'hFFFF_FFFF);
            end
            4: begin
               csr_write(vfr_pkg::CSR_THROAT, 32'd0);
               csr_write(vfr_pkg::CSR_SCALE, 32'd1 << 20);
            end
            5: begin
               csr_write(vfr_pkg::CSR_FLOW_MODE, 32'd0);
               csr_write(vfr_pkg::CSR_INLET, 32'd500);
               csr_write(vfr_pkg::CSR_THROAT, 32'd500);
               csr_write(vfr_pkg::CSR_SCALE, vfr_pkg::RST_SCALE);
            end
            6: begin
               csr_write(vfr_pkg::CSR_FLOW_MODE, 32'd1);
               csr_write(vfr_pkg::CSR_INLET, 32'd30000);
               csr_write(vfr_pkg::CSR_THROAT, 32'd12000);
               csr_write(vfr_pkg::CSR_DENSITY, 32'd0);
            end
            7: begin
               csr_write(vfr_pkg::CSR_INLET, 32'd1000000);
               csr_write(vfr_pkg::CSR_THROAT, 32'd999999);
               csr_write(vfr_pkg::CSR_DENSITY, $urandom);
               csr_write(vfr_pkg::CSR_SCALE, 32'd0);
            end
            default: begin
               csr_write(vfr_pkg::CSR_FLOW_MODE, $urandom);
               csr_write(vfr_pkg::CSR_INLET, $urandom_range(1000, 1000000));
               csr_write(vfr_pkg::CSR_THROAT, $urandom_range(1, 999));
               csr_write(vfr_pkg::CSR_DENSITY, $urandom_range(1, 32'hFFFF_FFFF));
               csr_write(vfr_pkg::CSR_SCALE, $urandom_range(1, 32'h0400_0000));
            end
         endcase
         // unused indexes are ignored
         csr_write(vfr_pkg::CSR_SCALE + vfr_pkg::CSR_IDX_W'(1 + $urandom_range(2)), $urandom);
         csr_we <= 1'b0;
         quiet = (ph == 6);
         if (ph == 2) stall_req = 1'b1;
         for (int n = 0; n < PER_PHASE; n++) begin
            a = pick_code();
            b = ($urandom_range(9) == 0) ? a : pick_code();
            if (ph == 4 && n == 70) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               wait_drained();
            end
            offer(a, b, 0, none_r);
         end
         req_ch.valid <= 1'b0;
         quiet = 1'b0;
      end

      waited = 0;
      while (pending_flows.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_flows.size() != 0) mismatches++;
      repeat (110) @(posedge clock);
      if (mismatches == 0) begin
         $display("venturi_flow_rate regression: pass");
      end else begin
         $display("venturi_flow_rate regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/vfr_pkg.sv
sv/vfr_req_if.sv
sv/vfr_rsp_if.sv
sv/vfr_coef.sv
sv/vfr_front.sv
sv/vfr_div.sv
sv/vfr_sqrt.sv
sv/venturi_flow_rate.sv
sim/venturi_flow_rate_test.sv
